// ===== hdl/server_hold_backoff_table_top_defines.svh =====
// Assertion macros shared by the checker of the server hold table.
// No dependencies; each macro expects clk and rst_n to be in scope.
`ifndef SERVER_HOLD_BACKOFF_TABLE_TOP_DEFINES_SVH
`define SERVER_HOLD_BACKOFF_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SHBT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHBT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/shbt_pkg.sv =====
// Shared types, codes and the backoff function of the server hold table.
// No dependencies; used by shbt_store and server_hold_backoff_table_top.
package shbt_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic [5:0] STRIKE_MAX = 6'd32;

  // Request codes.
  localparam logic [2:0] REQ_REFUSE = 3'd0;
  localparam logic [2:0] REQ_CLEAR  = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_PICK   = 3'd3;
  localparam logic [2:0] REQ_QUERY  = 3'd4;

  // Hold kinds, which are also the refusal kinds.
  localparam logic [2:0] K_NONE     = 3'd0;
  localparam logic [2:0] K_THROTTLE = 3'd1;
  localparam logic [2:0] K_BAN      = 3'd2;
  localparam logic [2:0] K_BAN_LEN  = 3'd3;
  localparam logic [2:0] K_PERM     = 3'd4;

  // Query status codes.
  localparam logic [1:0] ST_ELIGIBLE  = 2'd0;
  localparam logic [1:0] ST_THROTTLED = 2'd1;
  localparam logic [1:0] ST_BANNED    = 2'd2;
  localparam logic [1:0] ST_PERMANENT = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_THROTTLE_BASE = 3'd0;
  localparam logic [2:0] CFG_THROTTLE_CAP  = 3'd1;
  localparam logic [2:0] CFG_BAN_BASE      = 3'd2;
  localparam logic [2:0] CFG_BAN_CAP       = 3'd3;
  localparam logic [2:0] CFG_BAN_GRACE     = 3'd4;
  localparam logic [2:0] CFG_ACTIVE_SLOTS  = 3'd5;

  localparam logic [30:0] RST_THROTTLE_BASE = 31'd60;
  localparam logic [30:0] RST_THROTTLE_CAP  = 31'd3600;
  localparam logic [30:0] RST_BAN_BASE      = 31'd3600;
  localparam logic [30:0] RST_BAN_CAP       = 31'd86400;
  localparam logic [19:0] RST_BAN_GRACE     = 20'd60;
  localparam logic [4:0]  RST_ACTIVE_SLOTS  = 5'd0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  strikes;
    logic [32:0] expiry;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

  typedef struct packed {
    logic        valid_slot;
    logic        found;
    logic [3:0]  picked_slot;
    logic [31:0] wait_secs;
    logic [1:0]  slot_status;
    logic [31:0] hold_secs;
    logic [5:0]  strike_count;
  } res_t;

  // Hold after n strikes (n >= 1): base doubled n-1 times, capped. The product
  // stays below 2^62, so no doubling is lost before the cap compare.
  function automatic logic [31:0] backoff(logic [30:0] base, logic [5:0] n,
                                          logic [30:0] cap);
    logic [5:0]  nm1;
    logic [61:0] s;
    nm1 = n - 6'd1;
    s   = {31'b0, base} << nm1[4:0];
    return (s < {31'b0, cap}) ? {1'b0, s[30:0]} : {1'b0, cap};
  endfunction

endpackage

// ===== hdl/shbt_store.sv =====
// Slot state memory of the server hold table: one write and one read port.
// Depends on shbt_pkg; entries never written since reset read as zero.
module shbt_store
  import shbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  wr_req_t           wr,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t             mem_r [SLOTS];
  logic [SLOTS-1:0]   vld_r;
  entry_t             rd_data_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Per-entry valid bits stand in for clearing the memory at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== hdl/server_hold_backoff_table_top.sv =====
// Server hold table with exponential backoff: sequencer around the slot memory.
// Depends on shbt_pkg and shbt_store.
//
// Usage: one request enters on the in_ channel (valid/stall) and yields
// exactly one result on the out_ channel (valid/stall). in_stall is high
// while a request is being worked on; the block takes one request at a time.
// Steps per request: a refusal reads its slot and, for a known kind, computes
// the backoff, picks the hold and writes the slot back; a query reads and
// decodes its slot; a clear writes the slot empty; an unknown or out-of-range
// request goes straight to its result. Remove shifts each later active slot
// down one place and empties the last; pick visits slots from the start slot
// until a free one is found or every active slot has been checked. Each slot
// visited by pick or remove is read and then checked or written back. A
// finished result sits in the output register; the next request is accepted
// while it waits, and its own result is held back until the receiver drops out_stall.
// Reset: synchronous, active low. State, out_valid and configuration registers
// take their defaults; all slots read as empty with no strikes, no clearing pass.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at the
// next edge and must only be issued while no request is in flight.
module server_hold_backoff_table_top
  import shbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [3:0]  in_slot,
  input  logic [2:0]  in_refusal_kind,
  input  logic [30:0] in_stated_secs,
  input  logic [31:0] in_now_secs,
  input  logic [3:0]  in_start_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_slot,
  output logic        out_found,
  output logic [3:0]  out_picked_slot,
  output logic [31:0] out_wait_secs,
  output logic [1:0]  out_slot_status,
  output logic [31:0] out_hold_secs,
  output logic [5:0]  out_strike_count
);

  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE, S_CALC, S_HOLD, S_WRITE, S_CLR,
    S_RM_RD, S_RM_WR, S_PK_RD, S_PK_CHK, S_PK_END, S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [30:0] tb_r, tb_nxt, tc_r, tc_nxt, bb_r, bb_nxt, bc_r, bc_nxt;
  logic [19:0] grace_r, grace_nxt;
  logic [4:0]  active_r, active_nxt;

  logic [2:0]        req_r, req_nxt, kind_r, kind_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt, idx_r, idx_nxt;
  logic [30:0]       stated_r, stated_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [5:0]        strike_r, strike_nxt;
  logic [31:0]       bthr_r, bthr_nxt, bban_r, bban_nxt, bfl_r, bfl_nxt;
  logic [31:0]       ssum_r, ssum_nxt, hold_r, hold_nxt;
  logic              have_r, have_nxt;
  logic [32:0]       soon_r, soon_nxt;
  res_t              res_r, res_nxt, out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  wr_req_t           wr;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  entry_t            rd_data;

  logic [CNT_W-1:0]  n_act;
  logic [32:0]       now_ext, q_diff, soon_diff;
  logic [5:0]        inc_strike;

  shbt_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign n_act      = (active_r > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(active_r);
  assign now_ext    = {1'b0, now_r};
  assign q_diff     = rd_data.expiry - now_ext;
  assign soon_diff  = soon_r - now_ext;
  assign inc_strike = (rd_data.strikes < STRIKE_MAX) ? rd_data.strikes + 6'd1
                                                     : rd_data.strikes;

  always_comb begin
    state_nxt     = state_r;
    tb_nxt        = tb_r;
    tc_nxt        = tc_r;
    bb_nxt        = bb_r;
    bc_nxt        = bc_r;
    grace_nxt     = grace_r;
    active_nxt    = active_r;
    req_nxt       = req_r;
    kind_nxt      = kind_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    stated_nxt    = stated_r;
    now_nxt       = now_r;
    cnt_nxt       = cnt_r;
    strike_nxt    = strike_r;
    bthr_nxt      = bthr_r;
    bban_nxt      = bban_r;
    bfl_nxt       = bfl_r;
    ssum_nxt      = ssum_r;
    hold_nxt      = hold_r;
    have_nxt      = have_r;
    soon_nxt      = soon_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr            = '0;
    rd_en         = 1'b0;
    rd_addr       = idx_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_THROTTLE_BASE: tb_nxt = cfg_wdata;
        CFG_THROTTLE_CAP:  tc_nxt = cfg_wdata;
        CFG_BAN_BASE:      bb_nxt = cfg_wdata;
        CFG_BAN_CAP:       bc_nxt = cfg_wdata;
        CFG_BAN_GRACE:     grace_nxt = cfg_wdata[19:0];
        CFG_ACTIVE_SLOTS:  active_nxt = cfg_wdata[4:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req_type;
          kind_nxt   = in_refusal_kind;
          slot_nxt   = in_slot;
          stated_nxt = in_stated_secs;
          now_nxt    = in_now_secs;
          res_nxt    = '0;
          state_nxt  = S_DONE;
          case (in_req_type)
            REQ_REFUSE: begin
              if ({1'b0, in_slot} < n_act) state_nxt = S_ISSUE;
            end
            REQ_CLEAR: begin
              if ({1'b0, in_slot} < CNT_W'(SLOTS)) state_nxt = S_CLR;
            end
            REQ_REMOVE: begin
              if ({1'b0, in_slot} < n_act) begin
                idx_nxt            = in_slot;
                res_nxt.valid_slot = 1'b1;
                state_nxt          = S_RM_RD;
              end
            end
            REQ_PICK: begin
              if (n_act != '0) begin
                idx_nxt   = ({1'b0, in_start_slot} >= n_act) ? '0 : in_start_slot;
                cnt_nxt   = '0;
                have_nxt  = 1'b0;
                soon_nxt  = '0;
                state_nxt = S_PK_RD;
              end
            end
            REQ_QUERY: begin
              if ({1'b0, in_slot} < CNT_W'(SLOTS)) state_nxt = S_ISSUE;
            end
            default: ;
          endcase
        end
      end

      S_ISSUE: begin
        rd_en     = 1'b1;
        rd_addr   = slot_r;
        state_nxt = S_CALC;
      end

      S_CALC: begin
        if (req_r == REQ_QUERY) begin
          res_nxt.valid_slot   = 1'b1;
          res_nxt.strike_count = rd_data.strikes;
          if (rd_data.kind == K_PERM) begin
            res_nxt.slot_status = ST_PERMANENT;
          end else if (rd_data.kind != K_NONE && rd_data.expiry > now_ext) begin
            res_nxt.slot_status = (rd_data.kind == K_THROTTLE) ? ST_THROTTLED : ST_BANNED;
            res_nxt.wait_secs   = q_diff[31:0];
          end
          state_nxt = S_DONE;
        end else if (kind_r >= K_THROTTLE && kind_r <= K_PERM) begin
          strike_nxt = inc_strike;
          bthr_nxt   = backoff(tb_r, inc_strike, tc_r);
          bban_nxt   = backoff(bb_r, inc_strike, bc_r);
          bfl_nxt    = backoff(tb_r, inc_strike, bc_r);
          ssum_nxt   = {1'b0, stated_r} + {12'b0, grace_r};
          state_nxt  = S_HOLD;
        end else begin
          // No action, but the slot's count is still reported.
          res_nxt.strike_count = rd_data.strikes;
          state_nxt            = S_DONE;
        end
      end

      S_HOLD: begin
        case (kind_r)
          K_THROTTLE: hold_nxt = bthr_r;
          K_BAN:      hold_nxt = bban_r;
          K_BAN_LEN:  hold_nxt = (ssum_r < bfl_r) ? bfl_r : ssum_r;
          default:    hold_nxt = '0;
        endcase
        state_nxt = S_WRITE;
      end

      S_WRITE: begin
        wr.en                = 1'b1;
        wr.addr              = slot_r;
        wr.data.kind         = kind_r;
        wr.data.strikes      = strike_r;
        wr.data.expiry       = (kind_r == K_PERM) ? '0 : now_ext + {1'b0, hold_r};
        res_nxt.valid_slot   = 1'b1;
        res_nxt.hold_secs    = hold_r;
        res_nxt.strike_count = strike_r;
        state_nxt            = S_DONE;
      end

      S_CLR: begin
        wr.en              = 1'b1;
        wr.addr            = slot_r;
        wr.data            = '0;
        res_nxt.valid_slot = 1'b1;
        state_nxt          = S_DONE;
      end

      S_RM_RD: begin
        if (({1'b0, idx_r} + CNT_W'(1)) < n_act) begin
          rd_en     = 1'b1;
          rd_addr   = idx_r + SLOT_W'(1);
          state_nxt = S_RM_WR;
        end else begin
          // Last active slot is emptied after the shift.
          wr.en     = 1'b1;
          wr.addr   = idx_r;
          wr.data   = '0;
          state_nxt = S_DONE;
        end
      end

      S_RM_WR: begin
        wr.en   = 1'b1;
        wr.addr = idx_r;
        wr.data = rd_data;
        if (idx_r == slot_r) res_nxt.strike_count = rd_data.strikes;
        idx_nxt   = idx_r + SLOT_W'(1);
        state_nxt = S_RM_RD;
      end

      S_PK_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_PK_CHK;
      end

      S_PK_CHK: begin
        if (rd_data.kind != K_PERM &&
            !(rd_data.kind != K_NONE && rd_data.expiry > now_ext)) begin
          res_nxt.found        = 1'b1;
          res_nxt.picked_slot  = 4'(idx_r);
          res_nxt.strike_count = rd_data.strikes;
          state_nxt            = S_DONE;
        end else begin
          if (rd_data.kind != K_PERM && (!have_r || rd_data.expiry < soon_r)) begin
            soon_nxt = rd_data.expiry;
            have_nxt = 1'b1;
          end
          if (cnt_r + CNT_W'(1) == n_act) begin
            state_nxt = S_PK_END;
          end else begin
            cnt_nxt   = cnt_r + CNT_W'(1);
            idx_nxt   = (({1'b0, idx_r} + CNT_W'(1)) == n_act) ? '0 : idx_r + SLOT_W'(1);
            state_nxt = S_PK_RD;
          end
        end
      end

      S_PK_END: begin
        res_nxt.wait_secs = have_r ? soon_diff[31:0] : '0;
        state_nxt         = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tb_r        <= RST_THROTTLE_BASE;
      tc_r        <= RST_THROTTLE_CAP;
      bb_r        <= RST_BAN_BASE;
      bc_r        <= RST_BAN_CAP;
      grace_r     <= RST_BAN_GRACE;
      active_r    <= RST_ACTIVE_SLOTS;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tb_r        <= tb_nxt;
      tc_r        <= tc_nxt;
      bb_r        <= bb_nxt;
      bc_r        <= bc_nxt;
      grace_r     <= grace_nxt;
      active_r    <= active_nxt;
    end
    req_r    <= req_nxt;
    kind_r   <= kind_nxt;
    slot_r   <= slot_nxt;
    idx_r    <= idx_nxt;
    stated_r <= stated_nxt;
    now_r    <= now_nxt;
    cnt_r    <= cnt_nxt;
    strike_r <= strike_nxt;
    bthr_r   <= bthr_nxt;
    bban_r   <= bban_nxt;
    bfl_r    <= bfl_nxt;
    ssum_r   <= ssum_nxt;
    hold_r   <= hold_nxt;
    have_r   <= have_nxt;
    soon_r   <= soon_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_valid_slot   = out_r.valid_slot;
  assign out_found        = out_r.found;
  assign out_picked_slot  = out_r.picked_slot;
  assign out_wait_secs    = out_r.wait_secs;
  assign out_slot_status  = out_r.slot_status;
  assign out_hold_secs    = out_r.hold_secs;
  assign out_strike_count = out_r.strike_count;

endmodule

// ===== hdl/shbt_chk.sv =====
// Port-level checker for server_hold_backoff_table_top, attached by bind.
// Depends on server_hold_backoff_table_top_defines.svh for the assertion macros.
`include "server_hold_backoff_table_top_defines.svh"

module shbt_chk
  import shbt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_valid_slot,
  input logic        out_found,
  input logic [31:0] out_wait_secs,
  input logic [1:0]  out_slot_status,
  input logic [31:0] out_hold_secs,
  input logic [5:0]  out_strike_count
);

  // One request at a time: after a transaction is taken the input is held off.
  `SHBT_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
                   "input not held off after accept")

  // A stalled result stays offered.
  `SHBT_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_wait_secs), "stalled result changed")

  // A pick result never reports a named slot as acted on.
  `SHBT_ASSERT_IMP(a_pick_excl, out_valid && out_found,
                   !out_valid_slot && out_slot_status == ST_ELIGIBLE && out_hold_secs == 32'd0,
                   "pick result mixed with slot result")

  // Strike counts saturate.
  `SHBT_ASSERT_IMP(a_strike_sat, out_valid, out_strike_count <= STRIKE_MAX,
                   "strike count beyond saturation")

  // A held status only comes from a query that was in range.
  `SHBT_ASSERT_IMP(a_status_query, out_valid && out_slot_status != ST_ELIGIBLE,
                   out_valid_slot && !out_found && out_hold_secs == 32'd0,
                   "status without in-range query")

endmodule

bind server_hold_backoff_table_top shbt_chk u_shbt_chk (.*);
